[design/stbs_pkg.sv]
// ============================================================================
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ============================================================================
package stbs_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 1024;
    localparam int unsigned VAL_W           = 32;
    localparam int unsigned POS_W           = 12;
    localparam int unsigned OPC_W           = 2;
    localparam int unsigned MODE_W          = 2;

    // Command codes
    localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPC_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OPC_W-1:0] OP_SEARCH = 2'd2;

    // Search modes; the unused code behaves as exact match
    localparam logic [MODE_W-1:0] MODE_EXACT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOWER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UPPER = 2'd2;

    localparam logic [POS_W-1:0] POS_MISS = '1;

    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic load;
        logic probe;
        logic narrow;
        logic found;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic range_open;
        logic hit;
    } t_dp_status;

endpackage

[design/sorted_table_binary_search.sv]
// ============================================================================
// sorted_table_binary_search
// Sorted table of signed 32-bit values with exact, lower-bound and
// upper-bound binary search.
// ============================================================================
// Usage:
//   Command channel: present i_cmd with start high; the transfer happens at
//   the rising edge where start is high and busy is low. Opcodes: clear the
//   table, append i_cmd.value at the next free index, search for i_cmd.value.
//   Result channel: o_result is shown for exactly one cycle with
//   o_result_valid high; the receiver cannot stall it, so take it then.
//   Clear gives no result. Append gives its result in the cycle after the
//   transfer (position written, or the depth with overflow set when full)
//   and busy stays low, so appends can follow back to back.
//   A search keeps busy high while it runs. The number of table probes is
//   at most ceil(log2(count + 1)), i.e. 11 for 1024 entries. Each probe
//   is a check step, which issues the registered memory read, then a
//   compare step; a search without an exact hit ends with one more check
//   of the empty interval. The result strobe follows the last busy cycle.
//   Configuration channel: write the 2-bit search mode with i_cfg_valid;
//   o_cfg_ready is always high. Write it only while the block is idle.
//   Reset (synchronous, active low) empties the table and selects the
//   lower-bound mode; table contents are not cleared.
// ============================================================================
module sorted_table_binary_search #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  stbs_pkg::t_in_item                 i_cmd,
    output logic                               o_result_valid,
    output stbs_pkg::t_out_item                o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stbs_pkg::MODE_W-1:0]        i_cfg_data
);
    import stbs_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       accept;

    // Mode register can take a write at any time
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Sequencer: decodes commands and steps the halving loop
    stbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_cmd.opcode),
        .i_status (dp_status),
        .busy     (busy),
        .o_cmd    (dp_cmd)
    );

    // Datapath: table memory, interval registers, result register
    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_value        (i_cmd.value),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_status       (dp_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // A dropped append always reports the full depth
    a_ovf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.overflow |->
            o_result.position == POS_W'(TABLE_DEPTH))
        else $error("overflow result with wrong position");

    // A search transfer makes the block busy
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd.opcode == OP_SEARCH) |=> busy)
        else $error("search accepted but block not busy");

    // An append transfer gives a result on the next cycle and leaves the block free
    a_append_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd.opcode == OP_APPEND) |=> o_result_valid && !busy)
        else $error("append without result");

    // A clear gives no result and does not stall the channel
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd.opcode == OP_CLEAR) |=> !o_result_valid && !busy)
        else $error("clear produced a result or stalled");

endmodule

[design/stbs_ctrl.sv]
// ============================================================================
// stbs_ctrl
// Sequencer for the search: accept a command, then alternate probe and
// compare until the interval closes or an exact hit is seen.
// ============================================================================
module stbs_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic [1:0]             i_opcode,
    input  stbs_pkg::t_dp_status   i_status,
    output logic                   busy,
    output stbs_pkg::t_dp_cmd      o_cmd
);
    import stbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && (i_opcode == OP_SEARCH)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.range_open) begin
                    n_state = ST_COMPARE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_COMPARE: begin
                if (i_status.hit) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    unique case (i_opcode)
                        OP_CLEAR:  o_cmd.clear  = 1'b1;
                        OP_APPEND: o_cmd.append = 1'b1;
                        OP_SEARCH: o_cmd.load   = 1'b1;
                        default:   o_cmd        = '0;
                    endcase
                end
            end
            ST_CHECK: begin
                if (i_status.range_open) begin
                    o_cmd.probe = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                end
            end
            ST_COMPARE: begin
                if (i_status.hit) begin
                    o_cmd.found = 1'b1;
                end else begin
                    o_cmd.narrow = 1'b1;
                end
            end
            default: busy = 1'b1;
        endcase
    end

endmodule

[design/stbs_dpath.sv]
// ============================================================================
// stbs_dpath
// Table memory, element count, search interval, mode register and the
// registered result.
// ============================================================================
module stbs_dpath #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  stbs_pkg::t_dp_cmd                 i_cmd,
    input  logic signed [stbs_pkg::VAL_W-1:0] i_value,
    input  logic                              i_cfg_we,
    input  logic [stbs_pkg::MODE_W-1:0]       i_cfg_data,
    output stbs_pkg::t_dp_status              o_status,
    output logic                              o_result_valid,
    output stbs_pkg::t_out_item               o_result
);
    import stbs_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic signed [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic [CW-1:0]           r_mid;
    logic signed [VAL_W-1:0] r_target;
    logic [MODE_W-1:0]       r_mode;

    logic                    r_res_valid;
    logic [POS_W-1:0]        r_res_pos;
    logic                    r_res_ovf;

    logic [CW-1:0] mid;
    logic          full;
    logic          exact;
    logic          upper;
    logic          lt;
    logic          eq;
    logic          go_right;

    assign mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign full  = (r_count == CW'(TABLE_DEPTH));
    assign exact = (r_mode != MODE_LOWER) && (r_mode != MODE_UPPER);
    assign upper = (r_mode == MODE_UPPER);
    assign lt    = (r_rd_data < r_target);
    assign eq    = (r_rd_data == r_target);
    assign go_right = upper ? (lt || eq) : lt;

    assign o_status.range_open = (r_lo < r_hi);
    assign o_status.hit        = exact && eq;

    // Table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_mem[r_count[AW-1:0]] <= i_value;
        end
    end

    // Table reads, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe) begin
            r_rd_data <= r_mem[mid[AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mode      <= MODE_LOWER;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append && !full) begin
                r_count <= r_count + 1'b1;
            end
            r_res_valid <= i_cmd.append || i_cmd.found || i_cmd.finish;
        end
    end

    // Search interval and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo     <= '0;
            r_hi     <= r_count;
            r_target <= i_value;
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.narrow) begin
            if (go_right) begin
                r_lo <= r_mid + 1'b1;
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.append) begin
            r_res_pos <= POS_W'(r_count);
            r_res_ovf <= full;
        end else if (i_cmd.found) begin
            r_res_pos <= POS_W'(r_mid);
            r_res_ovf <= 1'b0;
        end else if (i_cmd.finish) begin
            r_res_pos <= exact ? POS_MISS : POS_W'(r_hi);
            r_res_ovf <= 1'b0;
        end
    end

    assign o_result_valid    = r_res_valid;
    assign o_result.position = r_res_pos;
    assign o_result.overflow = r_res_ovf;

endmodule
